// File: rtl/wnv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnv_pkg
// Shared types, constants and helpers for the tiling cellular noise block.
// ----------------------------------------------------------------------------
package wnv_pkg;

    localparam int EDGE_VOXELS = 128;
    localparam int VOXEL_W     = 7;
    localparam int CELL_W      = 6;
    localparam int POS_W       = 22;
    localparam int DIFF_W      = 24;
    localparam int ERR_W       = 22;
    localparam int SQ_W        = 42;
    localparam int DIST_W      = 44;
    localparam int CAP_W       = 37;
    localparam int LEVEL_W     = 28;
    localparam int NOISE_W     = 8;
    localparam int NBR_COUNT   = 27;

    localparam logic [31:0] HASH_MUL   = 32'h045d_9f3b;
    localparam logic [31:0] SEED_MUL   = 32'd3517;
    localparam logic [31:0] SEED_ADD   = 32'd12345;
    localparam logic [22:0] SCALE_MUL  = 23'd6502500;
    localparam logic [27:0] THR_MUL    = 28'd169;
    localparam logic [CAP_W-1:0] DIST_CAP = CAP_W'(64'd1 << 36);

    localparam logic [1:0] OFF_DEC  = 2'd0;
    localparam logic [1:0] OFF_SAME = 2'd1;
    localparam logic [1:0] OFF_INC  = 2'd2;

    typedef struct packed {
        logic [2:0][POS_W-1:0] pos;
        logic [DIST_W-1:0]     best;
    } wnv_ctx_t;

    typedef struct packed {
        logic [CELL_W-1:0]   g;
        logic [2*CELL_W-1:0] gg;
    } wnv_geom_t;

    function automatic logic [CELL_W-1:0] wnv_nbr(input logic [CELL_W-1:0] c,
                                                  input logic [1:0] off,
                                                  input logic [CELL_W-1:0] g);
        logic [CELL_W-1:0] r;
        case (off)
            OFF_DEC:  r = (c == '0) ? g - CELL_W'(1) : c - CELL_W'(1);
            OFF_INC:  r = (c == g - CELL_W'(1)) ? '0 : c + CELL_W'(1);
            default:  r = c;
        endcase
        return r;
    endfunction

    function automatic logic signed [ERR_W-1:0] wnv_wrap(input logic signed [DIFF_W-1:0] d,
                                                         input logic [CELL_W-1:0] g);
        logic signed [DIFF_W-1:0] half;
        logic signed [DIFF_W-1:0] full;
        logic signed [DIFF_W-1:0] r;
        half = $signed({3'b000, g, 15'd0});
        full = $signed({2'b00, g, 16'd0});
        r    = d;
        if (d > half)
        begin
            r = d - full;
        end
        else if (d < -half)
        begin
            r = d + full;
        end
        return r[ERR_W-1:0];
    endfunction

endpackage

// File: rtl/wnv_voxel_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnv_voxel_if
// Voxel coordinate channel: valid, ready and one coordinate per transaction.
// ----------------------------------------------------------------------------
interface wnv_voxel_if;
    logic       valid;
    logic       ready;
    logic [6:0] voxel_x;
    logic [6:0] voxel_y;
    logic [6:0] voxel_z;

    modport source (output valid, output voxel_x, output voxel_y, output voxel_z,
                    input ready);
    modport sink   (input valid, input voxel_x, input voxel_y, input voxel_z,
                    output ready);
endinterface

// File: rtl/wnv_noise_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnv_noise_if
// Noise result channel: valid, ready and one 8-bit value per transaction.
// ----------------------------------------------------------------------------
interface wnv_noise_if;
    logic       valid;
    logic       ready;
    logic [7:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

// File: rtl/worley_noise_voxel.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// worley_noise_voxel
// Tiling 3D cellular noise (nearest feature point) for one voxel per
// transaction, testing the 27 surrounding cells in a chain of cells.
// ----------------------------------------------------------------------------
//  channel   | dir | transaction
//  voxel     | in  | voxel_x, voxel_y, voxel_z
//  noise     | out | noise_value
//  cfg_we    | in  | cells_per_axis write (cfg_data)
//
//  One voxel per cycle unless stalled; the pipeline has one position stage,
//  27 cells of seven stages each, nine scaling stages and the output register.
//  Reset clears all valid bits and sets cells_per_axis to 8.
//  A held result stalls the pipeline only when another result is ready to
//  leave it; bubbles keep moving and voxels keep entering meanwhile.
// ----------------------------------------------------------------------------
module worley_noise_voxel (
    input  logic        clk,
    input  logic        rst_n,
    wnv_voxel_if.sink   voxel,
    wnv_noise_if.source noise,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_data
);
    import wnv_pkg::*;

    logic [CELL_W-1:0]   g_reg;
    logic [CELL_W-1:0]   g_eff;
    logic [2*CELL_W-1:0] gg_reg;
    wnv_geom_t           geom;
    logic                advance;
    logic                front_vld_reg;
    wnv_ctx_t            front_ctx_reg;
    wnv_ctx_t            front_ctx_next;
    logic                chain_vld [NBR_COUNT+1];
    wnv_ctx_t            chain_ctx [NBR_COUNT+1];
    logic                tail_vld;
    logic [NOISE_W-1:0]  tail_level;
    logic                out_vld_reg;
    logic                out_vld_next;
    logic [NOISE_W-1:0]  out_val_reg;

    assign g_eff     = (g_reg == '0) ? CELL_W'(1) : g_reg;
    assign geom.g    = g_eff;
    assign geom.gg   = gg_reg;
    assign advance   = !(tail_vld && out_vld_reg && !noise.ready);
    assign voxel.ready = advance;

    always_comb
    begin
        logic [12:0] prod [3];
        prod[0] = 13'(voxel.voxel_x) * 13'(g_eff);
        prod[1] = 13'(voxel.voxel_y) * 13'(g_eff);
        prod[2] = 13'(voxel.voxel_z) * 13'(g_eff);
        for (int a = 0; a < 3; a++)
        begin
            front_ctx_next.pos[a] = POS_W'(29'({prod[a], 16'd0}) >> $clog2(EDGE_VOXELS));
        end
        front_ctx_next.best = '1;
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (noise.ready)
        begin
            out_vld_next = 1'b0;
        end
        if (advance && tail_vld)
        begin
            out_vld_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_reg         <= CELL_W'(8);
            front_vld_reg <= 1'b0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                g_reg <= cfg_data;
            end
            if (advance)
            begin
                front_vld_reg <= voxel.valid;
            end
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gg_reg <= 12'(g_eff) * 12'(g_eff);
        if (advance)
        begin
            front_ctx_reg <= front_ctx_next;
        end
        if (advance && tail_vld)
        begin
            out_val_reg <= tail_level;
        end
    end

    assign chain_vld[0] = front_vld_reg;
    assign chain_ctx[0] = front_ctx_reg;

    for (genvar j = 0; j < NBR_COUNT; j++)
    begin : g_cell
        wnv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .geom      (geom),
            .off_x     (2'(j % 3)),
            .off_y     (2'((j / 3) % 3)),
            .off_z     (2'(j / 9)),
            .in_valid  (chain_vld[j]),
            .in_ctx    (chain_ctx[j]),
            .out_valid (chain_vld[j+1]),
            .out_ctx   (chain_ctx[j+1])
        );
    end

    wnv_scale u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (chain_vld[NBR_COUNT]),
        .in_dist   (chain_ctx[NBR_COUNT].best),
        .out_valid (tail_vld),
        .out_level (tail_level)
    );

    assign noise.valid       = out_vld_reg;
    assign noise.noise_value = out_val_reg;

`ifndef SYNTH
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !voxel.ready |-> (noise.valid && !noise.ready && tail_vld))
        else $error("input stalled without a waiting result");

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> (g_reg == $past(cfg_data)))
        else $error("cells_per_axis not written");

    a_no_result_loss: assert property (@(posedge clk) disable iff (!rst_n)
        (tail_vld && noise.valid && !noise.ready) |=> tail_vld)
        else $error("finished result dropped during stall");
`endif

endmodule

// File: rtl/wnv_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnv_cell
// One neighbour test: hash the neighbour's feature point, measure the wrapped
// squared distance and keep the running minimum. Seven pipeline stages.
// ----------------------------------------------------------------------------
module wnv_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  wnv_pkg::wnv_geom_t geom,
    input  logic [1:0]        off_x,
    input  logic [1:0]        off_y,
    input  logic [1:0]        off_z,
    input  logic              in_valid,
    input  wnv_pkg::wnv_ctx_t in_ctx,
    output logic              out_valid,
    output wnv_pkg::wnv_ctx_t out_ctx
);
    import wnv_pkg::*;

    logic [6:0] vld_reg;
    logic [6:0] vld_next;

    wnv_ctx_t ctx_reg [7];

    logic [2:0][CELL_W-1:0] n0_reg, n1_reg, n2_reg, n3_reg;
    logic [2:0][CELL_W-1:0] n0_next;
    logic [17:0]            nzgg0_reg, nzgg0_next;
    logic [11:0]            nyg0_reg, nyg0_next;
    logic [31:0]            seed1_reg, seed1_next;
    logic [2:0][31:0]       t2_reg, t2_next;
    logic [2:0][15:0]       frac3_reg, frac3_next;
    logic signed [ERR_W-1:0] e4_reg [3];
    logic signed [ERR_W-1:0] e4_next [3];
    logic [2:0][SQ_W-1:0]   sq5_reg, sq5_next;
    logic [DIST_W-1:0]      best_next;

    always_comb
    begin
        logic [17:0]              idx;
        logic [31:0]              s;
        logic [31:0]              u;
        logic [POS_W-1:0]         f;
        logic signed [DIFF_W-1:0] d;
        logic signed [2*ERR_W-1:0] p;
        logic [DIST_W-1:0]        sum;

        vld_next = {vld_reg[5:0], in_valid};

        n0_next[0] = wnv_nbr(in_ctx.pos[0][POS_W-1:16], off_x, geom.g);
        n0_next[1] = wnv_nbr(in_ctx.pos[1][POS_W-1:16], off_y, geom.g);
        n0_next[2] = wnv_nbr(in_ctx.pos[2][POS_W-1:16], off_z, geom.g);
        nzgg0_next = 18'(n0_next[2]) * 18'(geom.gg);
        nyg0_next  = 12'(n0_next[1]) * 12'(geom.g);

        idx        = nzgg0_reg + 18'(nyg0_reg) + 18'(n0_reg[0]);
        seed1_next = 32'(idx) * SEED_MUL + SEED_ADD;

        for (int a = 0; a < 3; a++)
        begin
            s          = seed1_reg + 32'(a);
            t2_next[a] = (s ^ (s >> 16)) * HASH_MUL;
            u          = (t2_reg[a] ^ (t2_reg[a] >> 16)) * HASH_MUL;
            frac3_next[a] = u[31:16];
            f          = {n3_reg[a], frac3_reg[a]};
            d          = $signed({2'b00, ctx_reg[3].pos[a]}) - $signed({2'b00, f});
            e4_next[a] = wnv_wrap(d, geom.g);
            p          = e4_reg[a] * e4_reg[a];
            sq5_next[a] = p[SQ_W-1:0];
        end

        sum       = DIST_W'(sq5_reg[0]) + DIST_W'(sq5_reg[1]) + DIST_W'(sq5_reg[2]);
        best_next = (sum < ctx_reg[5].best) ? sum : ctx_reg[5].best;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ctx_reg[0] <= in_ctx;
            for (int i = 1; i < 6; i++)
            begin
                ctx_reg[i] <= ctx_reg[i-1];
            end
            ctx_reg[6].pos  <= ctx_reg[5].pos;
            ctx_reg[6].best <= best_next;
            n0_reg    <= n0_next;
            n1_reg    <= n0_reg;
            n2_reg    <= n1_reg;
            n3_reg    <= n2_reg;
            nzgg0_reg <= nzgg0_next;
            nyg0_reg  <= nyg0_next;
            seed1_reg <= seed1_next;
            t2_reg    <= t2_next;
            frac3_reg <= frac3_next;
            e4_reg    <= e4_next;
            sq5_reg   <= sq5_next;
        end
    end

    assign out_valid = vld_reg[6];
    assign out_ctx   = ctx_reg[6];

endmodule

// File: rtl/wnv_scale.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnv_scale
// Cap the minimum squared distance, scale it and find the 8-bit level by a
// pipelined binary search, one bit per stage.
// ----------------------------------------------------------------------------
module wnv_scale (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          in_valid,
    input  logic [wnv_pkg::DIST_W-1:0]    in_dist,
    output logic                          out_valid,
    output logic [wnv_pkg::NOISE_W-1:0]   out_level
);
    import wnv_pkg::*;

    logic [NOISE_W:0]   vld_reg;
    logic [NOISE_W:0]   vld_next;
    logic [LEVEL_W-1:0] lvl_reg [NOISE_W+1];
    logic [LEVEL_W-1:0] lvl_next [NOISE_W+1];
    logic [NOISE_W-1:0] k_reg [NOISE_W+1];
    logic [NOISE_W-1:0] k_next [NOISE_W+1];

    always_comb
    begin
        logic [CAP_W-1:0]   capped;
        logic [54:0]        lo;
        logic [27:0]        hi;
        logic [NOISE_W-1:0] trial;
        logic [15:0]        sq;
        logic [LEVEL_W-1:0] thr;

        vld_next = {vld_reg[NOISE_W-1:0], in_valid};

        capped      = (in_dist > DIST_W'(DIST_CAP)) ? DIST_CAP : in_dist[CAP_W-1:0];
        lo          = 55'(capped[31:0]) * 55'(SCALE_MUL);
        hi          = 28'(capped[CAP_W-1:32]) * 28'(SCALE_MUL);
        lvl_next[0] = hi + 28'(lo[54:32]);
        k_next[0]   = '0;

        for (int i = 1; i <= NOISE_W; i++)
        begin
            trial       = k_reg[i-1] | (NOISE_W'(1) << (NOISE_W - i));
            sq          = 16'(trial) * 16'(trial);
            thr         = 28'(sq) * THR_MUL;
            lvl_next[i] = lvl_reg[i-1];
            k_next[i]   = (lvl_reg[i-1] >= thr) ? trial : k_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (advance)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            lvl_reg <= lvl_next;
            k_reg   <= k_next;
        end
    end

    assign out_valid = vld_reg[NOISE_W];
    assign out_level = k_reg[NOISE_W];

endmodule
